// ===== src/assert_macros.svh =====
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CHK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/r2q_pkg.sv =====
// Types, constants and step functions for the matrix to quaternion block.
`timescale 1ns / 1ps
`default_nettype none
package r2q_pkg;

    localparam int QW = 16;   // component width
    localparam int NW = 17;   // off-diagonal sum width
    localparam int CW = 15;   // candidate width
    localparam int RW = 30;   // padded radicand width
    localparam int SQ_STEPS = RW / 2;
    localparam int QB = 16;   // quotient bits
    localparam int RMW = 18;  // square root remainder width

    localparam logic [1:0] PIV_X = 2'd0;
    localparam logic [1:0] PIV_Y = 2'd1;
    localparam logic [1:0] PIV_Z = 2'd2;
    localparam logic [1:0] PIV_W = 2'd3;

    localparam logic signed [QW-1:0] Q_MAX = 16'sh7fff;
    localparam logic signed [QW-1:0] Q_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [QW-1:0] m00;
        logic signed [QW-1:0] m01;
        logic signed [QW-1:0] m02;
        logic signed [QW-1:0] m10;
        logic signed [QW-1:0] m11;
        logic signed [QW-1:0] m12;
        logic signed [QW-1:0] m20;
        logic signed [QW-1:0] m21;
        logic signed [QW-1:0] m22;
    } mat_t;

    typedef struct packed {
        logic [CW-1:0]        p;
        logic [1:0]           pivot;
        logic [3:0][NW-1:0]   num;
    } mid_t;

    typedef struct packed {
        logic [3:0][QW-1:0]   q;
        logic [1:0]           pivot;
    } out_t;

    typedef struct packed {
        logic [RMW-1:0] rem;
        logic [CW-1:0]  root;
    } sq_t;

    typedef struct packed {
        logic [CW-1:0] rem;
        logic [QB-1:0] quo;
    } dv_t;

    // One digit of the square root: bring in two radicand bits.
    function automatic sq_t sq_step(input logic [RMW-1:0] rem, input logic [CW-1:0] root,
                                    input logic [1:0] pair);
        logic [RMW:0] acc;
        logic [RMW:0] trial;
        sq_t r;
        acc   = {rem[RMW-2:0], pair};
        trial = {{(RMW-CW-1){1'b0}}, root, 2'b01};
        if (acc >= trial)
        begin
            r.rem  = RMW'(acc - trial);
            r.root = {root[CW-2:0], 1'b1};
        end
        else
        begin
            r.rem  = acc[RMW-1:0];
            r.root = {root[CW-2:0], 1'b0};
        end
        return r;
    endfunction

    // One quotient bit of a restoring division.
    function automatic dv_t dv_step(input logic [CW-1:0] rem, input logic [QB-1:0] quo,
                                    input logic nb, input logic [CW-1:0] p);
        logic [CW:0] acc;
        dv_t r;
        acc = {rem, nb};
        if (acc >= {1'b0, p})
        begin
            r.rem = CW'(acc - {1'b0, p});
            r.quo = {quo[QB-2:0], 1'b1};
        end
        else
        begin
            r.rem = acc[CW-1:0];
            r.quo = {quo[QB-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/r2q_fifo.sv =====
// Small register queue between and after the pipeline parts.
`timescale 1ns / 1ps
`default_nettype none
module r2q_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_reg, wr_next;
    logic [AW-1:0]    rd_reg, rd_next;
    logic [AW:0]      cnt_reg, cnt_next;

    always_comb
    begin
        // Wrap at the last entry so depths that are not a power of two work.
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        if (push)
        begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : AW'(wr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : AW'(rd_reg + 1'b1);
        end
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= wdata;
        end
    end

    assign rdata = mem_reg[rd_reg];
    assign empty = (cnt_reg == '0);
endmodule
`default_nettype wire

// ===== src/r2q_front.sv =====
// Front part: diagonal sums, four pipelined square roots, pivot choice.
`timescale 1ns / 1ps
`default_nettype none
module r2q_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  r2q_pkg::mat_t in_mat,
    output logic          out_valid,
    output r2q_pkg::mid_t out_item
);
    import r2q_pkg::*;

    localparam int NS = SQ_STEPS + 1;

    logic                  v_reg   [NS];
    logic [3:0][RW-1:0]    x_reg   [NS];
    logic [3:0][RMW-1:0]   rem_reg [NS];
    logic [3:0][CW-1:0]    root_reg[NS];
    logic [5:0][NW-1:0]    off_reg [NS];

    logic [3:0][RW-1:0]    x0;
    logic [5:0][NW-1:0]    off0;
    logic signed [17:0]    t [4];
    logic signed [17:0]    d00, d11, d22;

    logic       outv_reg;
    mid_t       item_reg, item_next;
    logic [1:0] piv;

    always_comb
    begin
        d00 = 18'(in_mat.m00);
        d11 = 18'(in_mat.m11);
        d22 = 18'(in_mat.m22);
        t[0] = 18'sd16384 + d00 - d11 - d22;
        t[1] = 18'sd16384 - d00 + d11 - d22;
        t[2] = 18'sd16384 - d00 - d11 + d22;
        t[3] = 18'sd16384 + d00 + d11 + d22;
        for (int i = 0; i < 4; i++)
        begin
            x0[i] = {1'b0, (t[i][17] ? 17'(-t[i]) : t[i][16:0]), 12'd0};
        end
        // Off-diagonal sums and differences, 17 bits each.
        off0[0] = NW'(in_mat.m01) + NW'(in_mat.m10);
        off0[1] = NW'(in_mat.m02) + NW'(in_mat.m20);
        off0[2] = NW'(in_mat.m12) + NW'(in_mat.m21);
        off0[3] = NW'(in_mat.m21) - NW'(in_mat.m12);
        off0[4] = NW'(in_mat.m02) - NW'(in_mat.m20);
        off0[5] = NW'(in_mat.m10) - NW'(in_mat.m01);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
            begin
                v_reg[s] <= 1'b0;
            end
            outv_reg <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
            outv_reg <= v_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x0;
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        off_reg[0]  <= off0;
        for (int s = 1; s < NS; s++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                {rem_reg[s][i], root_reg[s][i]} <= sq_step(rem_reg[s-1][i],
                    root_reg[s-1][i], x_reg[s-1][i][RW-1:RW-2]);
                x_reg[s][i] <= {x_reg[s-1][i][RW-3:0], 2'b00};
            end
            off_reg[s] <= off_reg[s-1];
        end
        item_reg <= item_next;
    end

    always_comb
    begin
        // Strict compare keeps the lower index on a tie.
        piv = PIV_X;
        for (int i = 1; i < 4; i++)
        begin
            if (root_reg[NS-1][i] > root_reg[NS-1][piv])
            begin
                piv = 2'(i);
            end
        end
        item_next.p     = root_reg[NS-1][piv];
        item_next.pivot = piv;
        item_next.num   = '0;
        unique case (piv)
            PIV_X:
            begin
                item_next.num[1] = off_reg[NS-1][0];
                item_next.num[2] = off_reg[NS-1][1];
                item_next.num[3] = off_reg[NS-1][3];
            end
            PIV_Y:
            begin
                item_next.num[0] = off_reg[NS-1][0];
                item_next.num[2] = off_reg[NS-1][2];
                item_next.num[3] = off_reg[NS-1][4];
            end
            PIV_Z:
            begin
                item_next.num[0] = off_reg[NS-1][1];
                item_next.num[1] = off_reg[NS-1][2];
                item_next.num[3] = off_reg[NS-1][5];
            end
            default:
            begin
                item_next.num[0] = off_reg[NS-1][3];
                item_next.num[1] = off_reg[NS-1][4];
                item_next.num[2] = off_reg[NS-1][5];
            end
        endcase
    end

    assign out_valid = outv_reg;
    assign out_item  = item_reg;
endmodule
`default_nettype wire

// ===== src/r2q_back.sv =====
// Back part: four pipelined dividers by the pivot, sign and saturation.
`timescale 1ns / 1ps
`default_nettype none
module r2q_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  r2q_pkg::mid_t in_item,
    output logic          out_valid,
    output r2q_pkg::out_t out_item
);
    import r2q_pkg::*;

    localparam int NS = QB + 1;

    logic               v_reg    [NS];
    logic [CW-1:0]      p_reg    [NS];
    logic [1:0]         piv_reg  [NS];
    logic [3:0]         neg_reg  [NS];
    logic [3:0]         ovf_reg  [NS];
    logic [3:0][QB-1:0] lo_reg   [NS];
    logic [3:0][CW-1:0] rem_reg  [NS];
    logic [3:0][QB-1:0] quo_reg  [NS];

    logic [3:0]         neg0, ovf0;
    logic [3:0][QB-1:0] lo0;
    logic [3:0][CW-1:0] rem0;
    logic [NW-1:0]      mag;
    logic [28:0]        dvd;

    logic outv_reg;
    out_t res_reg, res_next;
    logic [QB-1:0] qm;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            neg0[i] = in_item.num[i][NW-1];
            mag     = neg0[i] ? NW'(-in_item.num[i]) : in_item.num[i];
            dvd     = {mag, 12'd0};
            // Quotient would need more than 16 bits.
            ovf0[i] = ({2'b00, dvd[28:16]} >= in_item.p);
            rem0[i] = {2'b00, dvd[28:16]};
            lo0[i]  = dvd[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
            begin
                v_reg[s] <= 1'b0;
            end
            outv_reg <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
            outv_reg <= v_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg[0]   <= in_item.p;
        piv_reg[0] <= in_item.pivot;
        neg_reg[0] <= neg0;
        ovf_reg[0] <= ovf0;
        lo_reg[0]  <= lo0;
        rem_reg[0] <= rem0;
        quo_reg[0] <= '0;
        for (int s = 1; s < NS; s++)
        begin
            p_reg[s]   <= p_reg[s-1];
            piv_reg[s] <= piv_reg[s-1];
            neg_reg[s] <= neg_reg[s-1];
            ovf_reg[s] <= ovf_reg[s-1];
            for (int i = 0; i < 4; i++)
            begin
                {rem_reg[s][i], quo_reg[s][i]} <= dv_step(rem_reg[s-1][i],
                    quo_reg[s-1][i], lo_reg[s-1][i][QB-1], p_reg[s-1]);
                lo_reg[s][i] <= {lo_reg[s-1][i][QB-2:0], 1'b0};
            end
        end
        res_reg <= res_next;
    end

    always_comb
    begin
        res_next.pivot = piv_reg[NS-1];
        qm = '0;
        for (int i = 0; i < 4; i++)
        begin
            qm = quo_reg[NS-1][i];
            if (piv_reg[NS-1] == 2'(i))
            begin
                res_next.q[i] = {1'b0, p_reg[NS-1]};
            end
            else if (p_reg[NS-1] == '0)
            begin
                res_next.q[i] = '0;
            end
            else if (neg_reg[NS-1][i])
            begin
                res_next.q[i] = (ovf_reg[NS-1][i] || qm > 16'd32768) ? Q_MIN : QW'(-qm);
            end
            else
            begin
                res_next.q[i] = (ovf_reg[NS-1][i] || qm[QB-1]) ? Q_MAX : qm;
            end
        end
    end

    assign out_valid = outv_reg;
    assign out_item  = res_reg;
endmodule
`default_nettype wire

// ===== src/rotation_matrix_to_quaternion_top.sv =====
// Path from request to result: front part, middle queue, back part, result queue.
// Throughput: one matrix per cycle while full is low; set by the fully pipelined square roots
// (one digit per stage) and dividers (one quotient bit per stage).
// full rises when MID_DEPTH requests are in the front or the middle queue.
// Reset (rst_n low, asynchronous) empties both queues and all pipeline valids.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion_top #(
    parameter int MID_DEPTH = 32,
    parameter int OUT_DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] m00,
    input  logic signed [15:0] m01,
    input  logic signed [15:0] m02,
    input  logic signed [15:0] m10,
    input  logic signed [15:0] m11,
    input  logic signed [15:0] m12,
    input  logic signed [15:0] m20,
    input  logic signed [15:0] m21,
    input  logic signed [15:0] m22,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] qx,
    output logic signed [15:0] qy,
    output logic signed [15:0] qz,
    output logic signed [15:0] qw,
    output logic [1:0]         pivot
);
    import r2q_pkg::*;

    localparam int FW = $clog2(MID_DEPTH) + 1;
    localparam int BW = $clog2(OUT_DEPTH) + 1;

    logic          acc_in, mid_pop, out_pop, mid_empty;
    logic          f_valid, b_valid;
    mat_t          mat;
    mid_t          f_item, mid_item;
    out_t          b_item, out_item;
    logic [FW-1:0] focc_reg, focc_next;
    logic [BW-1:0] bocc_reg, bocc_next;

    assign mat = '{m00: m00, m01: m01, m02: m02, m10: m10, m11: m11,
                   m12: m12, m20: m20, m21: m21, m22: m22};

    // Credits: count requests taken but not yet drained from the next queue.
    assign full    = (focc_reg == FW'(MID_DEPTH));
    assign acc_in  = push && !full;
    assign mid_pop = !mid_empty && (bocc_reg != BW'(OUT_DEPTH));
    assign out_pop = pop && !empty;

    always_comb
    begin
        focc_next = focc_reg + FW'(acc_in) - FW'(mid_pop);
        bocc_next = bocc_reg + BW'(mid_pop) - BW'(out_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focc_reg <= '0;
            bocc_reg <= '0;
        end
        else
        begin
            focc_reg <= focc_next;
            bocc_reg <= bocc_next;
        end
    end

    r2q_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (acc_in),
        .in_mat   (mat),
        .out_valid(f_valid),
        .out_item (f_item)
    );

    r2q_fifo #(.WIDTH($bits(mid_t)), .DEPTH(MID_DEPTH)) u_mid_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (f_valid),
        .wdata(f_item),
        .pop  (mid_pop),
        .rdata(mid_item),
        .empty(mid_empty)
    );

    r2q_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (mid_pop),
        .in_item  (mid_item),
        .out_valid(b_valid),
        .out_item (b_item)
    );

    r2q_fifo #(.WIDTH($bits(out_t)), .DEPTH(OUT_DEPTH)) u_out_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (b_valid),
        .wdata(b_item),
        .pop  (out_pop),
        .rdata(out_item),
        .empty(empty)
    );

    assign qx    = out_item.q[0];
    assign qy    = out_item.q[1];
    assign qz    = out_item.q[2];
    assign qw    = out_item.q[3];
    assign pivot = out_item.pivot;
endmodule
`default_nettype wire

// ===== src/r2q_checker.sv =====
// Port-level checks for the matrix to quaternion block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module r2q_port_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic signed [15:0] qx,
    input logic signed [15:0] qy,
    input logic signed [15:0] qz,
    input logic signed [15:0] qw,
    input logic [1:0]         pivot
);
    import r2q_pkg::*;

    logic signed [15:0] slot_q;

    always_comb
    begin
        case (pivot)
            PIV_X:   slot_q = qx;
            PIV_Y:   slot_q = qy;
            PIV_Z:   slot_q = qz;
            default: slot_q = qw;
        endcase
    end

    // The diagonal sums add to four, so the pivot is at least one half.
    `CHK_ALWAYS(a_pivot_low, empty || slot_q >= 16'sd8192, "pivot component below 0.5")
    `CHK_ALWAYS(a_pivot_high, empty || slot_q <= 16'sd21675, "pivot component above bound")
    `CHK_NEXT(a_hold_valid, !empty && !pop, !empty, "result dropped while stalled")
    `CHK_NEXT(a_hold_data, !empty && !pop,
        $stable(qx) && $stable(qy) && $stable(qz) && $stable(qw) && $stable(pivot),
        "result changed while stalled")
endmodule

bind rotation_matrix_to_quaternion_top r2q_port_checker u_r2q_checker (.*);
`default_nettype wire
